@@ hdl/bts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_pkg: shared types, constants and mask tables
// Hit-or-miss mask tables for shrink/thin/skeleton passes, register map,
// sequencer states and sizing constants.
// ----------------------------------------------------------------------------
package bts_pkg;

  localparam int unsigned MAX_DIM = 128;
  localparam int unsigned DEPTH   = MAX_DIM * MAX_DIM;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned DW      = $clog2(MAX_DIM + 1);
  localparam int unsigned PCW     = 15;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;
  localparam logic [1:0] REG_COLS = 2'd2;

  // mode codes
  localparam logic [1:0] MODE_SHRINK = 2'd0;
  localparam logic [1:0] MODE_THIN   = 2'd1;
  localparam logic [1:0] MODE_SKEL   = 2'd2;

  // func codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // neighbor sequence: bits 0..7 E,NE,N,NW,W,SW,S,SE, then center, then eval
  localparam logic [3:0] NB_E   = 4'd0;
  localparam logic [3:0] NB_NE  = 4'd1;
  localparam logic [3:0] NB_N   = 4'd2;
  localparam logic [3:0] NB_NW  = 4'd3;
  localparam logic [3:0] NB_W   = 4'd4;
  localparam logic [3:0] NB_SW  = 4'd5;
  localparam logic [3:0] NB_S   = 4'd6;
  localparam logic [3:0] NB_SE  = 4'd7;
  localparam logic [3:0] NB_CTR = 4'd8;
  localparam logic [3:0] K_EVAL = 4'd9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MARK,
    ST_ERASE,
    ST_DONE
  } bts_state_e;

  localparam int unsigned NCOND = 66;
  localparam int unsigned NST   = 37;
  localparam int unsigned NK    = 26;

  localparam logic [7:0] COND_PAT [0:NCOND-1] = '{
    8'h02,8'h08,8'h20,8'h80,8'h01,8'h04,8'h10,8'h40,
    8'h03,8'h06,8'h0C,8'h18,8'h30,8'h60,8'hC0,8'h81,
    8'h05,8'h14,8'h50,8'h41,
    8'h0D,8'h85,8'h16,8'h43,8'h07,8'h1C,8'h70,8'hC1,
    8'h8D,8'h36,
    8'h83,8'h0E,8'h38,8'hE0,
    8'h0F,8'h87,8'h1E,8'h3C,8'h78,8'hF0,8'hE1,8'hC3,
    8'h8F,8'h3E,8'hF8,8'hE3,
    8'hC7,8'h1F,8'h7C,8'hF1,
    8'hCF,8'hE7,8'h3F,8'h9F,8'h7E,8'hFC,8'hF9,8'hF3,
    8'hEF,8'hBF,8'hFE,8'hFB,
    8'hDF,8'h7F,8'hFD,8'hF7
  };

  // bit0 shrink, bit1 thin, bit2 skeleton
  localparam logic [2:0] COND_MODES [0:NCOND-1] = '{
    3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,
    3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,
    3'd6,3'd6,3'd6,3'd6,
    3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,
    3'd3,3'd3,
    3'd7,3'd7,3'd7,3'd7,
    3'd7,3'd7,3'd7,3'd7,3'd7,3'd7,3'd7,3'd7,
    3'd7,3'd7,3'd7,3'd7,
    3'd7,3'd7,3'd7,3'd7,
    3'd7,3'd7,3'd7,3'd7,3'd7,3'd7,3'd7,3'd7,
    3'd7,3'd7,3'd7,3'd7,
    3'd4,3'd4,3'd4,3'd4
  };

  localparam logic [7:0] ST_ONES [0:NST-1] = '{
    8'h02,8'h08,8'h40,8'h01, 8'h03,8'h06,8'h0C,8'h18,
    8'h30,8'h60,8'hC0,8'h81, 8'h16,8'h0D,8'h85,8'h43,
    8'h22,8'h88,8'h22,8'h88, 8'h1C,
    8'h15,8'h15,8'h51,8'h51, 8'h54,8'h54,8'h45,8'h45,
    8'h0A,8'h28,8'hA0,8'h82, 8'h25,8'h94,8'h52,8'h49
  };
  localparam logic [7:0] ST_ZEROS [0:NST-1] = '{
    8'hFD,8'hF7,8'hBF,8'hFE, 8'hFC,8'hF9,8'hF3,8'hE7,
    8'hCF,8'h9F,8'h3F,8'h7E, 8'hE9,8'hF2,8'h7A,8'hBC,
    8'hD8,8'h63,8'h8D,8'h36, 8'h00,
    8'hC2,8'h68,8'h2C,8'h86, 8'hA1,8'h0B,8'h1A,8'hB0,
    8'h00,8'h00,8'h00,8'h00, 8'h52,8'h49,8'h25,8'h94
  };
  localparam logic [7:0] ST_ANY [0:NST-1] = '{
    8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,
    8'h05,8'h14,8'h50,8'h41, 8'h00,
    8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,
    8'hE0,8'h83,8'h0E,8'h38, 8'h00,8'h00,8'h00,8'h00
  };

  localparam logic [7:0] K_ONES [0:NK-1] = '{
    8'h80,8'h20,8'h02,8'h08, 8'h40,8'h01,8'h10,8'h04,
    8'h05,8'h14,8'h41,8'h50, 8'h1C,8'hC1,
    8'h15,8'h54,8'h51,8'h45, 8'h0A,8'h28,8'hA0,8'h82,
    8'h25,8'h94,8'h52,8'h49
  };
  localparam logic [7:0] K_ZEROS [0:NK-1] = '{
    8'h7F,8'hDF,8'hFD,8'hF7, 8'hBF,8'hFE,8'hEF,8'hFB,
    8'hFA,8'hEB,8'hBE,8'hAF, 8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,
    8'h52,8'h49,8'h25,8'h94
  };
  localparam logic [7:0] K_ANY [0:NK-1] = '{
    8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00, 8'hE0,8'h83,8'h0E,8'h38,
    8'h00,8'h00,8'h00,8'h00
  };

  function automatic logic cond_hit(input logic [7:0] m, input logic [1:0] md);
    logic [2:0] mb;
    logic       hit;
    unique case (md)
      MODE_SHRINK: mb = 3'b001;
      MODE_THIN:   mb = 3'b010;
      MODE_SKEL:   mb = 3'b100;
      default:     mb = 3'b000;
    endcase
    hit = 1'b0;
    for (int k = 0; k < NCOND; k++) begin
      if (COND_PAT[k] == m && (COND_MODES[k] & mb) != 3'b000) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic mask_ok(input logic [7:0] m, input logic [7:0] ones,
                                   input logic [7:0] zeros, input logic [7:0] any);
    return ((m & ones) == ones) && ((m & zeros) == 8'h00) &&
           (any == 8'h00 || (m & any) != 8'h00);
  endfunction

  function automatic logic uncond_hit(input logic [7:0] m, input logic skel);
    logic hit;
    hit = 1'b0;
    if (skel) begin
      for (int k = 0; k < NK; k++) begin
        if (mask_ok(m, K_ONES[k], K_ZEROS[k], K_ANY[k])) hit = 1'b1;
      end
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (mask_ok(m, ST_ONES[k], ST_ZEROS[k], ST_ANY[k])) hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

@@ hdl/bts_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_ram: generic single-write, single-read RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module bts_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/binary_thin_shrink_skeleton_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_thin_shrink_skeleton_core: binary shrink/thin/skeleton engine
// Two-stage hit-or-miss passes over a stored one-bit frame until stable.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: a transaction is taken when start is high and busy low.
//    func_i=0 writes pixel_in_i at the next raster position, func_i=1 reads
//    the next result pixel. Writes and reads share one raster position.
//  - A write gives no result, except the final write of the frame: it starts
//    processing and, when the frame is stable, one result with done_res_o=1
//    and pass_count_o is strobed on out_valid_o.
//  - A read's result (image RAM registered read) shows on the cycle after
//    acceptance; last_o marks the final pixel of the frame.
//  - Processing: each pass sweeps the frame twice (mark, then erase). Border
//    pixels take a single step; interior pixels take nine reads through the
//    single RAM read port, then an evaluate step.
//  - Mark RAM needs no clearing pass: the mark sweep writes every entry of
//    the frame before the erase sweep reads any.
//  - Results are held for exactly one cycle; the receiver cannot stall.
//  - Reset returns to idle, position 0, mode thinning, 128x128 frame.
//    Image contents are not cleared.
//  - Registers (APB, 4-byte stride): 0 mode, 1 row_count, 2 column_count.
// ----------------------------------------------------------------------------
module binary_thin_shrink_skeleton_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        func_i,
  input  logic        pixel_in_i,
  output logic        out_valid_o,
  output logic        pixel_out_o,
  output logic        last_o,
  output logic        done_res_o,
  output logic [14:0] pass_count_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bts_pkg::*;

  // configuration
  logic [1:0] mode_q;
  logic [7:0] rows_q, cols_q;
  logic [7:0] rows_c, cols_c;
  logic       cfg_wr;

  // sequencer
  bts_state_e state_q, state_d;
  logic [AW-1:0]  pos_q, pos_eff;
  logic [15:0]    total;
  logic           final_px;
  logic           accept;
  logic           last_q;
  logic [DW-2:0]  r_q, c_q;
  logic [AW-1:0]  sp_q;
  logic [3:0]     k_q;
  logic [7:0]     nb_q;
  logic           chg_q;
  logic [PCW-1:0] pass_q;
  logic           border, pix_end, frame_end, row_end;
  logic [AW-1:0]  off, nb_addr;
  logic [2:0]     nb_idx;
  logic           erase_now, mark_val;

  // memories
  logic          img_we, img_wdata, img_rdata;
  logic [AW-1:0] img_waddr, img_raddr;
  logic          mk_we, mk_wdata, mk_rdata;
  logic [AW-1:0] mk_addr;
  logic          scan_rd;

  // frame size, clamped to 3..MAX_DIM
  always_comb begin
    rows_c = (rows_q < 8'd3) ? 8'd3 : ((rows_q > 8'(MAX_DIM)) ? 8'(MAX_DIM) : rows_q);
    cols_c = (cols_q < 8'd3) ? 8'd3 : ((cols_q > 8'(MAX_DIM)) ? 8'(MAX_DIM) : cols_q);
  end

  assign total    = 16'(rows_c) * 16'(cols_c);
  assign pos_eff  = (16'(pos_q) >= total) ? '0 : pos_q;
  assign final_px = (16'(pos_eff) + 16'd1) == total;
  assign accept   = start && !busy;

  // APB register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[3:2])
      REG_MODE: prdata = {30'd0, mode_q};
      REG_ROWS: prdata = {24'd0, rows_q};
      REG_COLS: prdata = {24'd0, cols_q};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_THIN;
      rows_q <= 8'(MAX_DIM);
      cols_q <= 8'(MAX_DIM);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MODE: mode_q <= pwdata[1:0];
        REG_ROWS: rows_q <= pwdata[7:0];
        REG_COLS: cols_q <= pwdata[7:0];
        default:  ;
      endcase
    end
  end

  // scan geometry
  assign border    = (r_q == '0) || ({1'b0, r_q} == rows_c - 8'd1) ||
                     (c_q == '0) || ({1'b0, c_q} == cols_c - 8'd1);
  assign row_end   = ({1'b0, c_q} == cols_c - 8'd1);
  assign pix_end   = border || (k_q == K_EVAL);
  assign frame_end = pix_end && row_end && ({1'b0, r_q} == rows_c - 8'd1);
  assign nb_idx    = 3'(k_q - 4'd1);

  // neighbor address: one adder, offset picked by the step counter
  always_comb begin
    unique case (k_q)
      NB_E:    off = AW'(1);
      NB_NE:   off = AW'(1) - AW'(cols_c);
      NB_N:    off = '0 - AW'(cols_c);
      NB_NW:   off = '0 - AW'(cols_c) - AW'(1);
      NB_W:    off = '0 - AW'(1);
      NB_SW:   off = AW'(cols_c) - AW'(1);
      NB_S:    off = AW'(cols_c);
      NB_SE:   off = AW'(cols_c) + AW'(1);
      NB_CTR:  off = '0;
      default: off = '0;
    endcase
  end
  assign nb_addr = sp_q + off;

  // pixel decisions at the evaluate step; the center arrives last
  assign mark_val  = !border && img_rdata && cond_hit(nb_q, mode_q);
  assign erase_now = (state_q == ST_ERASE) && !border && (k_q == K_EVAL) &&
                     mk_rdata && !uncond_hit(nb_q, mode_q == MODE_SKEL);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && func_i == FUNC_READ) state_d = ST_READ;
        else if (accept && final_px) state_d = ST_MARK;
      end
      ST_READ:  state_d = ST_IDLE;
      ST_MARK:  if (frame_end) state_d = ST_ERASE;
      ST_ERASE: begin
        if (frame_end) state_d = (chg_q || erase_now) ? ST_MARK : ST_DONE;
      end
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    busy         = (state_q != ST_IDLE);
    out_valid_o  = 1'b0;
    pixel_out_o  = 1'b0;
    last_o       = 1'b0;
    done_res_o   = 1'b0;
    pass_count_o = '0;
    img_we       = 1'b0;
    img_waddr    = sp_q;
    img_wdata    = 1'b0;
    img_raddr    = nb_addr;
    mk_we        = 1'b0;
    mk_wdata     = mark_val;
    scan_rd      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        img_raddr = pos_eff;
        img_waddr = pos_eff;
        img_wdata = pixel_in_i;
        img_we    = accept && func_i == FUNC_WRITE;
      end
      ST_READ: begin
        out_valid_o = 1'b1;
        pixel_out_o = img_rdata;
        last_o      = last_q;
      end
      ST_MARK: begin
        mk_we   = pix_end;
        scan_rd = 1'b1;
      end
      ST_ERASE: begin
        img_we  = erase_now;
        scan_rd = 1'b1;
      end
      ST_DONE: begin
        out_valid_o  = 1'b1;
        done_res_o   = 1'b1;
        pass_count_o = pass_q;
      end
      default: ;
    endcase
  end

  assign mk_addr = pix_end ? sp_q : nb_addr;

  // datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      last_q  <= 1'b0;
      r_q     <= '0;
      c_q     <= '0;
      sp_q    <= '0;
      k_q     <= '0;
      chg_q   <= 1'b0;
      pass_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        pos_q  <= final_px ? '0 : pos_eff + AW'(1);
        last_q <= final_px;
        if (func_i == FUNC_WRITE && final_px) begin
          pass_q <= '0;
          chg_q  <= 1'b0;
          r_q    <= '0;
          c_q    <= '0;
          sp_q   <= '0;
          k_q    <= '0;
        end
      end
      if (scan_rd) begin
        if (erase_now) chg_q <= 1'b1;
        if (pix_end) begin
          k_q <= '0;
          if (frame_end) begin
            r_q  <= '0;
            c_q  <= '0;
            sp_q <= '0;
            if (state_q == ST_ERASE) begin
              chg_q <= 1'b0;
              if (pass_q != {PCW{1'b1}}) pass_q <= pass_q + PCW'(1);
            end
          end else begin
            sp_q <= sp_q + AW'(1);
            if (row_end) begin
              c_q <= '0;
              r_q <= r_q + 1'b1;
            end else begin
              c_q <= c_q + 1'b1;
            end
          end
        end else begin
          k_q <= k_q + 4'd1;
        end
      end
    end
  end

  // neighbor shift-in: read data of step k-1 lands at step k
  always_ff @(posedge clk_i) begin
    if (scan_rd && !border && k_q != '0 && k_q <= NB_CTR) begin
      nb_q[nb_idx] <= (state_q == ST_MARK) ? img_rdata : mk_rdata;
    end
  end

  bts_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_img (
    .clk_i   (clk_i),
    .we_i    (img_we),
    .waddr_i (img_waddr),
    .wdata_i (img_wdata),
    .raddr_i (img_raddr),
    .rdata_o (img_rdata)
  );

  bts_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_mark (
    .clk_i   (clk_i),
    .we_i    (mk_we),
    .waddr_i (sp_q),
    .wdata_i (mk_wdata),
    .raddr_i (mk_addr),
    .rdata_o (mk_rdata)
  );

endmodule

@@ hdl/bts_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_checker: port-level checks for the skeleton core
// Result strobe and field consistency over time.
// ----------------------------------------------------------------------------
module bts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        busy,
  input logic        out_valid_o,
  input logic        pixel_out_o,
  input logic        last_o,
  input logic        done_res_o,
  input logic [14:0] pass_count_o
);

  // a result only ends a transaction in progress
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy) else $error("result without busy");

  // each result occupies a single cycle
  a_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o) else $error("result held two cycles");

  // completion result carries no pixel
  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_res_o |-> out_valid_o && !last_o && !pixel_out_o && pass_count_o != '0)
    else $error("bad completion result");

  // read results carry no pass count
  a_read_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> pass_count_o == '0)
    else $error("pass count on read");

endmodule

bind binary_thin_shrink_skeleton_core bts_checker u_bts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .busy         (busy),
  .out_valid_o  (out_valid_o),
  .pixel_out_o  (pixel_out_o),
  .last_o       (last_o),
  .done_res_o   (done_res_o),
  .pass_count_o (pass_count_o)
);

@@ tb/sv/binary_thin_shrink_skeleton_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_thin_shrink_skeleton_core_tb: self-checking bench for the core
// Loads small frames and a few extreme-sized ones, lets the core run its
// mark/erase passes to convergence and reads the frames back. Every result
// is checked against a typed value or an in-bench shrink/thin/skeleton model.
// ----------------------------------------------------------------------------
module binary_thin_shrink_skeleton_core_tb;
  import bts_pkg::*;

  localparam int unsigned STORE   = 128 * 128;
  localparam int unsigned PC_SAT  = 32767;
  localparam logic [1:0]  MODE_NONE = 2'd3;  // no conditional mask applies

  // conditional masks and their mode sets (bit0 shrink, bit1 thin, bit2 skel)
  localparam logic [7:0] CM_PAT [0:65] = '{
    8'h02,8'h08,8'h20,8'h80,8'h01,8'h04,8'h10,8'h40,
    8'h03,8'h06,8'h0C,8'h18,8'h30,8'h60,8'hC0,8'h81,
    8'h05,8'h14,8'h50,8'h41,
    8'h0D,8'h85,8'h16,8'h43,8'h07,8'h1C,8'h70,8'hC1,
    8'h8D,8'h36,
    8'h83,8'h0E,8'h38,8'hE0,
    8'h0F,8'h87,8'h1E,8'h3C,8'h78,8'hF0,8'hE1,8'hC3,
    8'h8F,8'h3E,8'hF8,8'hE3,
    8'hC7,8'h1F,8'h7C,8'hF1,
    8'hCF,8'hE7,8'h3F,8'h9F,8'h7E,8'hFC,8'hF9,8'hF3,
    8'hEF,8'hBF,8'hFE,8'hFB,
    8'hDF,8'h7F,8'hFD,8'hF7
  };
  localparam logic [2:0] CM_SET [0:65] = '{
    3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,
    3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,
    3'd6,3'd6,3'd6,3'd6,
    3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,
    3'd3,3'd3,
    3'd7,3'd7,3'd7,3'd7,
    3'd7,3'd7,3'd7,3'd7,3'd7,3'd7,3'd7,3'd7,
    3'd7,3'd7,3'd7,3'd7,
    3'd7,3'd7,3'd7,3'd7,
    3'd7,3'd7,3'd7,3'd7,3'd7,3'd7,3'd7,3'd7,
    3'd7,3'd7,3'd7,3'd7,
    3'd4,3'd4,3'd4,3'd4
  };

  // unconditional masks, shrink/thin set
  localparam logic [7:0] ST1 [0:36] = '{
    8'h02,8'h08,8'h40,8'h01, 8'h03,8'h06,8'h0C,8'h18,
    8'h30,8'h60,8'hC0,8'h81, 8'h16,8'h0D,8'h85,8'h43,
    8'h22,8'h88,8'h22,8'h88, 8'h1C,
    8'h15,8'h15,8'h51,8'h51, 8'h54,8'h54,8'h45,8'h45,
    8'h0A,8'h28,8'hA0,8'h82, 8'h25,8'h94,8'h52,8'h49
  };
  localparam logic [7:0] ST0 [0:36] = '{
    8'hFD,8'hF7,8'hBF,8'hFE, 8'hFC,8'hF9,8'hF3,8'hE7,
    8'hCF,8'h9F,8'h3F,8'h7E, 8'hE9,8'hF2,8'h7A,8'hBC,
    8'hD8,8'h63,8'h8D,8'h36, 8'h00,
    8'hC2,8'h68,8'h2C,8'h86, 8'hA1,8'h0B,8'h1A,8'hB0,
    8'h00,8'h00,8'h00,8'h00, 8'h52,8'h49,8'h25,8'h94
  };
  localparam logic [7:0] STA [0:36] = '{
    8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,
    8'h05,8'h14,8'h50,8'h41, 8'h00,
    8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,
    8'hE0,8'h83,8'h0E,8'h38, 8'h00,8'h00,8'h00,8'h00
  };

  // unconditional masks, skeleton set
  localparam logic [7:0] SK1 [0:25] = '{
    8'h80,8'h20,8'h02,8'h08, 8'h40,8'h01,8'h10,8'h04,
    8'h05,8'h14,8'h41,8'h50, 8'h1C,8'hC1,
    8'h15,8'h54,8'h51,8'h45, 8'h0A,8'h28,8'hA0,8'h82,
    8'h25,8'h94,8'h52,8'h49
  };
  localparam logic [7:0] SK0 [0:25] = '{
    8'h7F,8'hDF,8'hFD,8'hF7, 8'hBF,8'hFE,8'hEF,8'hFB,
    8'hFA,8'hEB,8'hBE,8'hAF, 8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,
    8'h52,8'h49,8'h25,8'h94
  };
  localparam logic [7:0] SKA [0:25] = '{
    8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00, 8'hE0,8'h83,8'h0E,8'h38,
    8'h00,8'h00,8'h00,8'h00
  };

  typedef struct packed {
    logic        pix;
    logic        lst;
    logic        dn;
    logic [14:0] pc;
  } pixel_result_t;

  // directed table row: either a register write or a command transaction
  typedef struct packed {
    logic          is_cfg;
    logic [1:0]    idx;     // register index
    logic [7:0]    data;    // register value, or {func, pixel} in bits 1:0
    logic          typed;   // expected result typed in below
    pixel_result_t res;
  } dir_row_t;

  localparam pixel_result_t R_NONE = '{pix: 1'b0, lst: 1'b0, dn: 1'b0, pc: 15'd0};
  localparam pixel_result_t R_DONE1 = '{pix: 1'b0, lst: 1'b0, dn: 1'b1, pc: 15'd1};
  localparam pixel_result_t R_ONE = '{pix: 1'b1, lst: 1'b0, dn: 1'b0, pc: 15'd0};
  localparam pixel_result_t R_ONE_LAST = '{pix: 1'b1, lst: 1'b1, dn: 1'b0, pc: 15'd0};

  localparam int unsigned NDIR = 31;
  localparam dir_row_t DIR_TAB [0:NDIR-1] = '{
    // 3x3 frame of all ones under shrinking: center sees 0xFF, nothing marked
    '{1'b1, REG_MODE, {6'd0, MODE_SHRINK}, 1'b0, R_NONE},
    '{1'b1, REG_ROWS, 8'd3, 1'b0, R_NONE},
    '{1'b1, REG_COLS, 8'd3, 1'b0, R_NONE},
    '{1'b0, 2'd0, 8'h01, 1'b0, R_NONE}, '{1'b0, 2'd0, 8'h01, 1'b0, R_NONE},
    '{1'b0, 2'd0, 8'h01, 1'b0, R_NONE}, '{1'b0, 2'd0, 8'h01, 1'b0, R_NONE},
    '{1'b0, 2'd0, 8'h01, 1'b0, R_NONE}, '{1'b0, 2'd0, 8'h01, 1'b0, R_NONE},
    '{1'b0, 2'd0, 8'h01, 1'b0, R_NONE}, '{1'b0, 2'd0, 8'h01, 1'b0, R_NONE},
    '{1'b0, 2'd0, 8'h01, 1'b1, R_DONE1},
    // read back: all ones, last flag on the ninth pixel
    '{1'b0, 2'd0, 8'h02, 1'b1, R_ONE}, '{1'b0, 2'd0, 8'h02, 1'b1, R_ONE},
    '{1'b0, 2'd0, 8'h02, 1'b1, R_ONE}, '{1'b0, 2'd0, 8'h02, 1'b1, R_ONE},
    '{1'b0, 2'd0, 8'h02, 1'b1, R_ONE}, '{1'b0, 2'd0, 8'h02, 1'b1, R_ONE},
    '{1'b0, 2'd0, 8'h02, 1'b1, R_ONE}, '{1'b0, 2'd0, 8'h02, 1'b1, R_ONE},
    '{1'b0, 2'd0, 8'h02, 1'b1, R_ONE_LAST},
    // mode three: no mask table, one pass that erases nothing
    '{1'b1, REG_MODE, {6'd0, MODE_NONE}, 1'b0, R_NONE},
    '{1'b0, 2'd0, 8'h01, 1'b0, R_NONE}, '{1'b0, 2'd0, 8'h00, 1'b0, R_NONE},
    '{1'b0, 2'd0, 8'h01, 1'b0, R_NONE}, '{1'b0, 2'd0, 8'h00, 1'b0, R_NONE},
    '{1'b0, 2'd0, 8'h01, 1'b0, R_NONE}, '{1'b0, 2'd0, 8'h00, 1'b0, R_NONE},
    '{1'b0, 2'd0, 8'h01, 1'b0, R_NONE}, '{1'b0, 2'd0, 8'h00, 1'b0, R_NONE},
    '{1'b0, 2'd0, 8'h00, 1'b1, R_DONE1}
  };

  // DUT signals
  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        func_i;
  logic        pixel_in_i;
  logic        out_valid_o;
  logic        pixel_out_o;
  logic        last_o;
  logic        done_res_o;
  logic [14:0] pass_count_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // frame model state
  logic          img_q   [0:STORE-1];
  logic          mark_q  [0:STORE-1];
  logic          written [0:STORE-1];
  int unsigned   raster_pos;
  logic [1:0]    cur_mode;
  logic [7:0]    cur_rows;
  logic [7:0]    cur_cols;

  pixel_result_t pending_q [$];
  int unsigned   err_cnt;
  int unsigned   item_cnt;
  int unsigned   send_gap_pct;

  binary_thin_shrink_skeleton_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .pixel_in_i   (pixel_in_i),
    .out_valid_o  (out_valid_o),
    .pixel_out_o  (pixel_out_o),
    .last_o       (last_o),
    .done_res_o   (done_res_o),
    .pass_count_o (pass_count_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- model

  function automatic int unsigned clamp_dim(input logic [7:0] v);
    if (v < 8'd3) return 3;
    if (v > 8'd128) return 128;
    return 32'(v);
  endfunction

  // neighbor word E,NE,N,NW,W,SW,S,SE in bits 0..7, of image or of marks
  function automatic logic [7:0] nbr_word(input logic of_marks, input int p,
                                          input int c);
    int          off [0:7];
    logic [7:0]  w;
    off = '{1, 1 - c, -c, -c - 1, -1, c - 1, c, c + 1};
    for (int n = 0; n < 8; n++)
      w[n] = of_marks ? mark_q[p + off[n]] : img_q[p + off[n]];
    return w;
  endfunction

  function automatic logic cond_match(input logic [7:0] w, input logic [1:0] md);
    logic [2:0] sel;
    sel = (md == MODE_NONE) ? 3'b000 : (3'b001 << md);
    for (int k = 0; k < 66; k++)
      if (CM_PAT[k] == w && (CM_SET[k] & sel) != 3'b000) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic keep_match(input logic [7:0] w, input logic skel);
    logic [7:0] o, z, a;
    int         n;
    n = skel ? 26 : 37;
    for (int k = 0; k < n; k++) begin
      o = skel ? SK1[k] : ST1[k];
      z = skel ? SK0[k] : ST0[k];
      a = skel ? SKA[k] : STA[k];
      if ((w & o) == o && (w & z) == 8'h00 && (a == 8'h00 || (w & a) != 8'h00))
        return 1'b1;
    end
    return 1'b0;
  endfunction

  // runs mark/erase passes to convergence, returns the pass count
  function automatic int unsigned settle_frame(input int r, input int c);
    int unsigned passes;
    logic        erased;
    int          p;
    passes = 0;
    do begin
      for (int i = 0; i < r * c; i++) mark_q[i] = 1'b0;
      erased = 1'b0;
      for (int y = 1; y + 1 < r; y++)
        for (int x = 1; x + 1 < c; x++) begin
          p = y * c + x;
          if (img_q[p] && cond_match(nbr_word(1'b0, p, c), cur_mode)) mark_q[p] = 1'b1;
        end
      for (int y = 1; y + 1 < r; y++)
        for (int x = 1; x + 1 < c; x++) begin
          p = y * c + x;
          if (mark_q[p] && !keep_match(nbr_word(1'b1, p, c), cur_mode == MODE_SKEL)) begin
            img_q[p] = 1'b0;
            erased   = 1'b1;
          end
        end
      if (passes < PC_SAT) passes++;
    end while (erased);
    return passes;
  endfunction

  function automatic int unsigned frame_total();
    return clamp_dim(cur_rows) * clamp_dim(cur_cols);
  endfunction

  // position the next transaction will use, after wrap on a size change
  function automatic int unsigned eff_pos();
    return (raster_pos >= frame_total()) ? 0 : raster_pos;
  endfunction

  // advance the model by one accepted transaction
  function automatic void predict_pixel(input logic f, input logic px,
                                        output logic has, output pixel_result_t e);
    int unsigned p;
    logic        fin;
    p   = eff_pos();
    fin = (p + 1 == frame_total());
    e   = R_NONE;
    has = 1'b1;
    if (f == FUNC_WRITE) begin
      img_q[p]   = px;
      written[p] = 1'b1;
      if (!fin) begin
        raster_pos = p + 1;
        has        = 1'b0;
      end else begin
        raster_pos = 0;
        e.dn = 1'b1;
        e.pc = 15'(settle_frame(clamp_dim(cur_rows), clamp_dim(cur_cols)));
      end
    end else begin
      e.pix      = img_q[p];
      e.lst      = fin;
      raster_pos = fin ? 0 : p + 1;
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  // one command transaction; start stays high unless idle cycles follow
  task automatic send_pixel(input logic f, input logic px, input logic typed,
                            input pixel_result_t typed_res);
    logic          has;
    pixel_result_t e;
    start      <= 1'b1;
    func_i     <= f;
    pixel_in_i <= px;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_pixel(f, px, has, e);
    if (has) pending_q.push_back(typed ? typed_res : e);
    item_cnt++;
    // each cycle idles with the given odds
    if ($urandom_range(0, 99) < send_gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < send_gap_pct) @(posedge clk_i);
    end
  endtask

  // drain outstanding results, then let a trailing write settle
  task automatic quiesce();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // APB write: setup then access cycle
  task automatic reg_write(input logic [1:0] idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MODE: cur_mode = val[1:0];
      REG_ROWS: cur_rows = val;
      REG_COLS: cur_cols = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // read if the pixel at the current position holds data, else write noise
  task automatic read_or_fill(input int unsigned dens);
    if (written[eff_pos()])
      send_pixel(FUNC_READ, 1'($urandom_range(0, 1)), 1'b0, R_NONE);
    else
      send_pixel(FUNC_WRITE, $urandom_range(0, 99) < dens, 1'b0, R_NONE);
  endtask

  // ---------------------------------------------------------------- checker

  always @(posedge clk_i) begin
    pixel_result_t e;
    if (rst_ni && out_valid_o) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result pix=%b last=%b done=%b passes=%0d", $time,
                 pixel_out_o, last_o, done_res_o, pass_count_o);
        err_cnt++;
      end else begin
        e = pending_q.pop_front();
        if (pixel_out_o !== e.pix) begin
          $display("%0t: pixel_out exp %b got %b", $time, e.pix, pixel_out_o);
          err_cnt++;
        end
        if (last_o !== e.lst) begin
          $display("%0t: last exp %b got %b", $time, e.lst, last_o);
          err_cnt++;
        end
        if (done_res_o !== e.dn) begin
          $display("%0t: done_res exp %b got %b", $time, e.dn, done_res_o);
          err_cnt++;
        end
        if (pass_count_o !== e.pc) begin
          $display("%0t: pass_count exp %0d got %0d", $time, e.pc, pass_count_o);
          err_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    int unsigned frame;
    int unsigned dens;
    int unsigned n_rd;
    int unsigned tot;
    logic        big;
    logic        fin_wr;

    rst_ni       = 1'b0;
    start        = 1'b0;
    func_i       = FUNC_WRITE;
    pixel_in_i   = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    err_cnt      = 0;
    item_cnt     = 0;
    send_gap_pct = 0;
    raster_pos   = 0;
    cur_mode     = MODE_THIN;
    cur_rows     = 8'd128;
    cur_cols     = 8'd128;
    for (int i = 0; i < STORE; i++) begin
      img_q[i]   = 1'b0;
      mark_q[i]  = 1'b0;
      written[i] = 1'b0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < NDIR; i++) begin
      if (DIR_TAB[i].is_cfg) begin
        quiesce();
        reg_write(DIR_TAB[i].idx, DIR_TAB[i].data);
      end else begin
        send_pixel(DIR_TAB[i].data[1], DIR_TAB[i].data[0], DIR_TAB[i].typed,
                   DIR_TAB[i].res);
      end
    end

    // random frames: load to the final write, then read back
    item_cnt = 0;
    frame    = 0;
    while (item_cnt < 1100) begin
      quiesce();
      case (frame)
        2: begin
          reg_write(REG_MODE, {6'd0, MODE_THIN});
          reg_write(REG_ROWS, 8'd128);
          reg_write(REG_COLS, 8'd3);
        end
        5: begin  // columns clamp to 128
          reg_write(REG_MODE, {6'd0, MODE_SKEL});
          reg_write(REG_ROWS, 8'd3);
          reg_write(REG_COLS, 8'd200);
        end
        8: begin  // both below range, clamp to 3x3
          reg_write(REG_MODE, {6'd0, MODE_SHRINK});
          reg_write(REG_ROWS, 8'd0);
          reg_write(REG_COLS, 8'd2);
        end
        11: begin
          reg_write(REG_MODE, {6'd0, MODE_NONE});
          reg_write(REG_ROWS, 8'd255);
          reg_write(REG_COLS, 8'd1);
        end
        default: begin
          if (frame == 3 || frame == 6 || frame == 9 || frame == 12 ||
              $urandom_range(0, 99) < 40) begin
            reg_write(REG_MODE, 8'($urandom_range(0, 2)));
            reg_write(REG_ROWS, 8'($urandom_range(3, 10)));
            reg_write(REG_COLS, 8'($urandom_range(3, 10)));
          end
        end
      endcase
      tot  = frame_total();
      big  = (tot > 100);
      dens = $urandom_range(15, 90);

      // load; a few reads mixed in where the pixel already holds data
      fin_wr = 1'b0;
      while (!fin_wr) begin
        send_gap_pct = (item_cnt < 370) ? 36 : (item_cnt < 740) ? 79 : 0;
        if (!big && $urandom_range(0, 99) < 8 && written[eff_pos()]) begin
          send_pixel(FUNC_READ, 1'b0, 1'b0, R_NONE);
        end else begin
          fin_wr = (eff_pos() + 1 == tot);
          send_pixel(FUNC_WRITE, $urandom_range(0, 99) < dens, 1'b0, R_NONE);
        end
      end

      // read back: small frames often in full, sometimes only a part; large ones only a part
      if (big)
        n_rd = $urandom_range(5, 30);
      else
        n_rd = ($urandom_range(0, 99) < 75) ? tot : $urandom_range(1, tot);
      repeat (n_rd) begin
        send_gap_pct = (item_cnt < 370) ? 36 : (item_cnt < 740) ? 79 : 0;
        read_or_fill(dens);
      end
      frame++;
    end

    quiesce();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #50_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ files.f @@
hdl/bts_pkg.sv
hdl/bts_ram.sv
hdl/binary_thin_shrink_skeleton_core.sv
hdl/bts_checker.sv
tb/sv/binary_thin_shrink_skeleton_core_tb.sv
